// ===== rtl/hsfx_pkg.sv =====
// shared constants and helpers for the horizontal sub-pixel fir
`timescale 1ns / 1ps

package hsfx_pkg;

  localparam int TAP_COUNT = 8;
  localparam int WIN_DEPTH = 7;
  localparam int PIX_W     = 12;
  localparam int TAP_W     = 8;
  localparam int FILL_W    = 3;
  localparam int PROD_W    = TAP_W + PIX_W + 1;
  localparam int SUM_W     = PROD_W + 3;
  localparam int RND_W     = SUM_W + 1;
  localparam int SHIFT_W   = 3;
  localparam int DEPTH_W   = 2;
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 32;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_TAPS_LOW    = 2'd0;
  localparam logic [CFG_AW-1:0] REG_TAPS_HIGH   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_ROUND_FIRST = 2'd2;
  localparam logic [CFG_AW-1:0] REG_DEPTH_MODE  = 2'd3;

  // depth codes
  localparam logic [DEPTH_W-1:0] DEPTH_10 = 2'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_12 = 2'd2;

  localparam logic [PIX_W-1:0] MAX_8  = 12'd255;
  localparam logic [PIX_W-1:0] MAX_10 = 12'd1023;
  localparam logic [PIX_W-1:0] MAX_12 = 12'd4095;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TAP_COUNT - 1);
  localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(WIN_DEPTH);

  // window slot feeding tap k; a shorter kernel skips the oldest slots
  function automatic int win_slot(input int k);
    return (8 - TAP_COUNT + k) % WIN_DEPTH;
  endfunction

  function automatic logic [PIX_W-1:0] depth_max(input logic [DEPTH_W-1:0] mode);
    logic [PIX_W-1:0] m;
    case (mode)
      DEPTH_10: m = MAX_10;
      DEPTH_12: m = MAX_12;
      default:  m = MAX_8;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/highbd_subpel_fir_x.sv =====
// top level of the horizontal 8-tap high bit-depth sub-pixel filter
`timescale 1ns / 1ps

// Takes one source pixel per beat and returns one filtered pixel per beat once
// the row window holds a full kernel span; the first pixels of each row only
// fill the window. A beat is accepted every cycle while the output side keeps
// up. An accepted pixel passes through the products register, the adder tree
// register, then rounding and clamping into the output register. A stall on
// the output backs up through the three stages and then stalls the input. The
// user must write taps, rounding shift and depth through the cfg port between
// rows while the pipeline is empty; the block itself does not enforce this.
module highbd_subpel_fir_x (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [hsfx_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [hsfx_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hsfx_pkg::PIX_W-1:0]  in_pixel,
  input  logic                        in_row_start,
  input  logic                        in_row_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hsfx_pkg::PIX_W-1:0]  out_pixel,
  output logic                        out_row_done
);

  localparam int TC  = hsfx_pkg::TAP_COUNT;
  localparam int WD  = hsfx_pkg::WIN_DEPTH;
  localparam int PW  = hsfx_pkg::PIX_W;
  localparam int TW  = hsfx_pkg::TAP_W;
  localparam int PRW = hsfx_pkg::PROD_W;
  localparam int SW  = hsfx_pkg::SUM_W;
  localparam int RW  = hsfx_pkg::RND_W;
  localparam int FW  = hsfx_pkg::FILL_W;

  // configuration
  logic [31:0]                        taps_low_r;
  logic [31:0]                        taps_high_r;
  logic [hsfx_pkg::SHIFT_W-1:0]       round_first_r;
  logic [hsfx_pkg::DEPTH_W-1:0]       depth_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_low_r    <= '0;
      taps_high_r   <= 32'h4000_0000;
      round_first_r <= 3'd3;
      depth_mode_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        hsfx_pkg::REG_TAPS_LOW:    taps_low_r    <= cfg_wdata;
        hsfx_pkg::REG_TAPS_HIGH:   taps_high_r   <= cfg_wdata;
        hsfx_pkg::REG_ROUND_FIRST: round_first_r <= cfg_wdata[hsfx_pkg::SHIFT_W-1:0];
        hsfx_pkg::REG_DEPTH_MODE:  depth_mode_r  <= cfg_wdata[hsfx_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic out_move, s2_move, s1_move, in_acc;

  assign out_move = !out_valid_r || !out_stall;
  assign s2_move  = !s2_valid_r || out_move;
  assign s1_move  = !s1_valid_r || s2_move;
  assign in_stall = !s1_move;
  assign in_acc   = in_valid && s1_move;

  // row window and fill
  logic [PW-1:0] win_r [WD];
  logic [FW-1:0] fill_cnt_r;
  logic [FW-1:0] fill_eff, fill_nxt;
  logic          win_full;

  always_comb begin
    fill_eff = in_row_start ? '0 : fill_cnt_r;
    win_full = (fill_eff >= hsfx_pkg::FILL_FULL);
    if (in_row_end) begin
      fill_nxt = '0;
    end else if (fill_eff < hsfx_pkg::FILL_MAX) begin
      fill_nxt = fill_eff + FW'(1);
    end else begin
      fill_nxt = hsfx_pkg::FILL_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r <= '0;
      for (int i = 0; i < WD; i++) win_r[i] <= '0;
    end else if (in_acc) begin
      fill_cnt_r <= fill_nxt;
      for (int i = 0; i < WD - 1; i++) win_r[i] <= win_r[i+1];
      win_r[WD-1] <= in_pixel;
    end
  end

  // stage 1: tap products
  logic [2*32-1:0]        taps_all;
  logic signed [PRW-1:0]  prod_nxt [TC];
  logic signed [PRW-1:0]  prod_r   [TC];
  logic                   s1_end_r;

  assign taps_all = {taps_high_r, taps_low_r};

  always_comb begin
    for (int k = 0; k < TC; k++) begin
      logic [PW-1:0] p;
      logic signed [TW-1:0] t;
      t = $signed(taps_all[k*TW +: TW]);
      p = (k == TC - 1) ? in_pixel : win_r[hsfx_pkg::win_slot(k)];
      // both operands at full product width so the multiply cannot wrap
      prod_nxt[k] = $signed({{(PRW-TW){t[TW-1]}}, t}) *
                    $signed({{(PRW-PW){1'b0}}, p});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_move) begin
      s1_valid_r <= in_acc && win_full;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      prod_r   <= prod_nxt;
      s1_end_r <= in_row_end;
    end
  end

  // stage 2: adder tree
  logic signed [SW-1:0] sum_nxt, sum_r;
  logic                 s2_end_r;

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < TC; k++) sum_nxt = sum_nxt + SW'(prod_r[k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_move) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      sum_r    <= sum_nxt;
      s2_end_r <= s1_end_r;
    end
  end

  // stage 3: two round shifts, then clamp to the pixel range
  logic [hsfx_pkg::SHIFT_W-1:0] r0, r1;
  logic signed [RW-1:0]         half0, half1, rnd_a, rnd_b;
  logic [PW-1:0]                max_pix, pix_nxt;
  logic [PW-1:0]                out_pixel_r;
  logic                         out_row_done_r;

  always_comb begin
    r0    = round_first_r;
    r1    = 3'd7 - r0;
    half0 = RW'((9'd1 << r0) >> 1);
    half1 = RW'((9'd1 << r1) >> 1);
    rnd_a = (RW'(sum_r) + half0) >>> r0;
    rnd_b = (rnd_a + half1) >>> r1;
    max_pix = hsfx_pkg::depth_max(depth_mode_r);
    // int16 saturation is covered by the tighter pixel clamp
    if (rnd_b < 0) begin
      pix_nxt = '0;
    end else if (rnd_b > $signed({1'b0, max_pix})) begin
      pix_nxt = max_pix;
    end else begin
      pix_nxt = rnd_b[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_move) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move) begin
      out_pixel_r    <= pix_nxt;
      out_row_done_r <= s2_end_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pixel    = out_pixel_r;
  assign out_row_done = out_row_done_r;

`ifndef ASSERT_OFF
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && out_valid_r))
    else $error("input stalled with a free pipeline stage");

  a_row_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_row_end) |=> (fill_cnt_r == '0))
    else $error("fill not cleared after row end beat");

  a_full_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && win_full) |=> s1_valid_r)
    else $error("full window beat did not enter the pipeline");

  a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel <= hsfx_pkg::depth_max(depth_mode_r)))
    else $error("result above configured depth range");
`endif

endmodule
